// File: src/dssf_pkg.sv
package dssf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam logic [7:0] SEG_POINT = 8'h7F;
  localparam logic [7:0] SEG_BLANK = 8'hFF;

  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_THOUSANDS = 2'd3;

  typedef struct packed {
    logic [3:0][3:0] digit;
    logic [1:0]      pt_pos;
    logic            pt_zero;
  } dssf_entry_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// File: src/dssf_front.sv
module dssf_front
  import dssf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] millivolts_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output dssf_entry_t push_entry_o
);

  logic            busy_q, busy_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [15:0]     rest_q, rest_d;
  logic [3:0][3:0] digit_q, digit_d;
  logic [1:0]      pos_q, pos_d;
  logic            zero_q, zero_d;

  logic [31:0] prod;
  logic [12:0] quo;
  logic [15:0] times10;
  logic [3:0]  rem;
  logic        done;
  logic        accept;

  assign prod    = {16'h0000, rest_q} * {16'h0000, DIV10_MUL};
  assign quo     = prod[31:DIV10_SHIFT];
  assign times10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
  assign rem     = rest_q[3:0] - times10[3:0];

  assign done         = busy_q && (cnt_q == 2'd3);
  assign push_valid_o = done;
  assign in_ready_o   = !busy_q || (done && push_ready_i);
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    push_entry_o         = '0;
    push_entry_o.digit   = digit_q;
    push_entry_o.digit[3] = rem;
    push_entry_o.pt_pos  = pos_q;
    push_entry_o.pt_zero = zero_q;
  end

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rest_d  = rest_q;
    digit_d = digit_q;
    pos_d   = pos_q;
    zero_d  = zero_q;
    if (busy_q && !done) begin
      digit_d[cnt_q] = rem;
      rest_d         = {3'b000, quo};
      cnt_d          = cnt_q + 2'd1;
    end
    if (done && push_ready_i) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      rest_d = millivolts_i;
      if (millivolts_i < 16'd10) begin
        pos_d  = POS_TENS;
        zero_d = 1'b1;
      end else if (millivolts_i < 16'd100) begin
        pos_d  = POS_HUNDREDS;
        zero_d = 1'b1;
      end else if (millivolts_i < 16'd1000) begin
        pos_d  = POS_THOUSANDS;
        zero_d = 1'b1;
      end else begin
        pos_d  = POS_THOUSANDS;
        zero_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q  <= rest_d;
    digit_q <= digit_d;
    pos_q   <= pos_d;
    zero_q  <= zero_d;
  end

endmodule

// File: src/dssf_queue.sv
module dssf_queue
  import dssf_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  dssf_entry_t push_entry_i,
  output logic        head_valid_o,
  input  logic        pop_i,
  output dssf_entry_t head_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dssf_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: src/dssf_back.sv
module dssf_back
  import dssf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  dssf_entry_t head_entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  position_o,
  output logic [3:0]  enable_n_o,
  output logic [7:0]  segments_n_o,
  output logic        last_o
);

  logic [2:0] step_q;
  logic       valid_q;
  logic [1:0] pos_q;
  logic [3:0] en_q;
  logic [7:0] seg_q;
  logic       last_q;

  logic [2:0] pt_frames;
  logic [2:0] dstep;
  logic [1:0] dpos;
  logic [3:0] blank;
  logic [1:0] f_pos;
  logic [7:0] f_seg;
  logic       f_last;
  logic       advance;

  assign pt_frames = head_entry_i.pt_zero ? 3'd2 : 3'd1;
  assign dstep     = step_q - pt_frames;
  assign dpos      = dstep[1:0];

  assign blank[3] = (head_entry_i.digit[3] == 4'd0);
  assign blank[2] = blank[3] && (head_entry_i.digit[2] == 4'd0);
  assign blank[1] = blank[2] && (head_entry_i.digit[1] == 4'd0);
  assign blank[0] = 1'b0;

  always_comb begin
    f_last = 1'b0;
    if (step_q == 3'd0) begin
      f_pos = head_entry_i.pt_pos;
      f_seg = SEG_POINT;
    end else if (head_entry_i.pt_zero && step_q == 3'd1) begin
      f_pos = head_entry_i.pt_pos;
      f_seg = seg_code(4'd0);
    end else begin
      f_pos  = dpos;
      f_seg  = blank[dpos] ? SEG_BLANK : seg_code(head_entry_i.digit[dpos]);
      f_last = (dpos == 2'd3);
    end
  end

  assign advance = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o   = advance && f_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      if (advance) begin
        valid_q <= 1'b1;
        step_q  <= f_last ? 3'd0 : step_q + 3'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pos_q  <= f_pos;
      en_q   <= ~(4'b1000 >> f_pos);
      seg_q  <= f_seg;
      last_q <= f_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign position_o   = pos_q;
  assign enable_n_o   = en_q;
  assign segments_n_o = seg_q;
  assign last_o       = last_q;

endmodule

// File: src/decimal_seven_segment_frames_unit.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[15:0] millivolts
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata position, enable_n, segments_n; tlast
//
// A reading is converted in the front, one decimal digit per cycle through a
// reciprocal multiply, and shown as five or six frames in the back, one per cycle
// while m_axis_tready is high; the back frame sequencer limits the sustained rate.
// With the pipeline empty, a reading passes the front, the queue and the back's output
// register to its first frame. Reset clears handshake and control state only. Either
// side stalls on its own: the entry queue absorbs up to QueueDepth converted readings.
module decimal_seven_segment_frames_unit
  import dssf_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] millivolts
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] position, [5:2] enable_n, [13:6] segments_n
  output logic        m_axis_tlast
);

  dssf_entry_t push_entry, head_entry;
  logic        push_valid, push_ready;
  logic        head_valid, pop;
  logic [1:0]  position;
  logic [3:0]  enable_n;
  logic [7:0]  segments_n;

  dssf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .millivolts_i (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  dssf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_entry_o (head_entry)
  );

  dssf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .position_o   (position),
    .enable_n_o   (enable_n),
    .segments_n_o (segments_n),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, segments_n, enable_n, position};

  a_last_on_thousands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> position == POS_THOUSANDS)
    else $error("last frame not on thousands position");

  a_enable_matches_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> enable_n == ~(4'b1000 >> position))
    else $error("digit enable does not match position");

  a_front_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("front accepted a reading while converting");

endmodule
